// ===== rtl/apjb_pkg.sv =====
// Shared constants, codes and record types of the audio playout jitter buffer.
package apjb_pkg;

   // Ring geometry. The ring is kept as 16-bit words so that one access moves a whole sample.
   localparam int RING_BYTES    = 8192;
   localparam int CHUNK_SAMPLES = 512;
   localparam int PTR_W         = $clog2(RING_BYTES);
   localparam int WORDS         = RING_BYTES / 2;
   localparam int WORD_W        = $clog2(WORDS);
   localparam int LVL_W         = $clog2(RING_BYTES + 1);
   localparam int CHUNK_W       = $clog2(CHUNK_SAMPLES + 1);

   // Field widths of the channels and registers.
   localparam int CMD_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int SEQ_W      = 8;
   localparam int SAMPLE_W   = 16;
   localparam int STATUS_W   = 3;
   localparam int STATE_W    = 2;
   localparam int LEVEL_W    = 14;
   localparam int BIG_CNT_W  = 24;
   localparam int CNT_W      = 16;
   localparam int THR_W      = 14;
   localparam int TMO_W      = 16;
   localparam int VOL_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(4096);
   localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(3000);
   localparam logic [VOL_W-1:0] VOL_RESET = '0;

   typedef enum logic [CMD_W-1:0] {
      CMD_START  = 3'd0,
      CMD_AUDIO  = 3'd1,
      CMD_END    = 3'd2,
      CMD_CANCEL = 3'd3,
      CMD_TICK   = 3'd4,
      CMD_PULL   = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NONE      = 3'd0,
      STAT_STARTED   = 3'd1,
      STAT_UNDERRUN  = 3'd2,
      STAT_FINISHED  = 3'd3,
      STAT_STALL_RST = 3'd4,
      STAT_ABORTED   = 3'd5
   } status_type;

   typedef enum logic [STATE_W-1:0] {
      MODE_IDLE      = 2'd0,
      MODE_BUFFERING = 2'd1,
      MODE_PLAYING   = 2'd2,
      MODE_DRAINING  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_THRESHOLD = 2'd0,
      CSR_STALL_TIMEOUT   = 2'd1,
      CSR_VOLUME_SHIFT    = 2'd2
   } csr_idx_type;

   // Everything a result reports apart from the sample itself.
   typedef struct packed {
      status_type             status;
      mode_type               mode;
      logic [LEVEL_W-1:0]     ring_level;
      logic [BIG_CNT_W-1:0]   rx_bytes;
      logic [CNT_W-1:0]       rx_chunks;
      logic [BIG_CNT_W-1:0]   rx_dropped;
      logic [CNT_W-1:0]       seq_gaps;
      logic [CNT_W-1:0]       underruns;
      logic [BIG_CNT_W-1:0]   idle_drop_bytes;
   } info_type;

   // Stage after acceptance, waiting for the ring read data.
   typedef struct packed {
      logic             sample_read;
      logic [VOL_W-1:0] vol;
      info_type         info;
   } stage_type;

   // Finished result held in the output register.
   typedef struct packed {
      logic                       sample_valid;
      logic signed [SAMPLE_W-1:0] sample;
      info_type                   info;
   } result_type;

endpackage

// ===== rtl/apjb_req_if.sv =====
// Request channel interface of the audio playout jitter buffer.
interface apjb_req_if import apjb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] data_byte;
   logic              packet_start;
   logic [SEQ_W-1:0]  seq;

   modport source (output valid, command, data_byte, packet_start, seq, input ready);
   modport sink (input valid, command, data_byte, packet_start, seq, output ready);
endinterface

// ===== rtl/apjb_rsp_if.sv =====
// Response channel interface of the audio playout jitter buffer.
interface apjb_rsp_if import apjb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       sample_valid;
   logic signed [SAMPLE_W-1:0] sample_left;
   logic signed [SAMPLE_W-1:0] sample_right;
   logic [STATUS_W-1:0]        status;
   logic [STATE_W-1:0]         stream_state;
   logic [LEVEL_W-1:0]         ring_level;
   logic [BIG_CNT_W-1:0]       rx_bytes;
   logic [CNT_W-1:0]           rx_chunks;
   logic [BIG_CNT_W-1:0]       rx_dropped;
   logic [CNT_W-1:0]           seq_gaps;
   logic [CNT_W-1:0]           underruns;
   logic [BIG_CNT_W-1:0]       idle_drop_bytes;

   modport source (output valid, sample_valid, sample_left, sample_right, status,
                   stream_state, ring_level, rx_bytes, rx_chunks, rx_dropped, seq_gaps,
                   underruns, idle_drop_bytes, input ready);
   modport sink (input valid, sample_valid, sample_left, sample_right, status,
                 stream_state, ring_level, rx_bytes, rx_chunks, rx_dropped, seq_gaps,
                 underruns, idle_drop_bytes, output ready);
endinterface

// ===== rtl/audio_playout_jitter_buffer.sv =====
// Audio playout jitter buffer: byte ring, stream control and speaker sample output.
//
// Usage: every request item on req_chan (start, audio byte, end marker, cancel, time
// tick or sample pull) produces exactly one response item on rsp_chan, in order. A
// response carries the pulled sample (when there is one), a status code, the stream
// state and all stream counters as they stand after that item.
// An accepted item is registered in the read stage while the ring memory is read, and
// then passes the volume shift into the output register, from which rsp_chan takes it.
// Throughput is one item per cycle while the receiver does not stall. The ring is a
// single-port memory of 16-bit words written one byte lane at a time; a pull reads one
// word, which is the whole little-endian sample, so each item uses the port at most once.
// The configuration registers (csr_*) are written with a single-cycle write enable
// and must only change while no item is in flight.
// Reset is synchronous and clears all control state and counters at once. The ring
// contents are not cleared; the pointers guarantee that only written bytes are read.
// When the receiver stalls, the output register holds its item and one more item can
// still be accepted into the read stage; after that req_chan.ready drops until the
// output register is taken.
module audio_playout_jitter_buffer import apjb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   apjb_req_if.sink              req_chan,
   apjb_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers.
   logic [THR_W-1:0] thr_ff;
   logic [TMO_W-1:0] tmo_ff;
   logic [VOL_W-1:0] vol_ff;

   // Stream state.
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [WORD_W-1:0]    rd_word_ff, rd_word_in;
   logic [LVL_W-1:0]     fill_ff, fill_in;
   logic [CHUNK_W-1:0]   chunk_ff, chunk_in;
   mode_type             mode_ff, mode_in;
   logic                 end_seen_ff, end_seen_in;
   logic                 seq_known_ff, seq_known_in;
   logic [SEQ_W-1:0]     exp_seq_ff, exp_seq_in;
   logic [TMO_W-1:0]     ticks_ff, ticks_in;
   logic [BIG_CNT_W-1:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]     packets_ff, packets_in;
   logic [BIG_CNT_W-1:0] drops_ff, drops_in;
   logic [CNT_W-1:0]     gaps_ff, gaps_in;
   logic [CNT_W-1:0]     unders_ff, unders_in;
   logic [BIG_CNT_W-1:0] idle_drops_ff, idle_drops_in;

   // Pipeline.
   logic       s1_valid_ff;
   stage_type  s1_ff, s1_in;
   logic       out_valid_ff;
   result_type out_ff, out_in;

   // Ring memory.
   logic [2*BYTE_W-1:0] ring_mem [WORDS];
   logic [2*BYTE_W-1:0] ring_rd_ff;
   logic                mem_we, mem_re;
   logic [WORD_W-1:0]   mem_addr;

   logic req_ready, req_fire, out_free;

   //------------------------------------------------------------------
   // Handshake and pipeline control.
   //------------------------------------------------------------------
   always_comb begin
      out_free  = !out_valid_ff || rsp_chan.ready;
      req_ready = !s1_valid_ff || out_free;
      req_fire  = req_chan.valid && req_ready;
   end

   //------------------------------------------------------------------
   // Configuration writes.
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         tmo_ff <= TMO_RESET;
         vol_ff <= VOL_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_START_THRESHOLD: thr_ff <= csr_wdata[THR_W-1:0];
            CSR_STALL_TIMEOUT:   tmo_ff <= csr_wdata[TMO_W-1:0];
            CSR_VOLUME_SHIFT:    vol_ff <= csr_wdata[VOL_W-1:0];
            default: begin
               // Index beyond the register list: the write is ignored.
            end
         endcase
      end
   end

   //------------------------------------------------------------------
   // Next state of the stream for the accepted item. All decisions are
   // made here in the accept cycle; only the sample value comes later,
   // from the ring read.
   //------------------------------------------------------------------
   always_comb begin
      logic             do_end;
      logic             pull_ok;
      logic             stalled;
      logic [TMO_W-1:0] tick_next;
      logic [SEQ_W-1:0] seq_diff;
      logic [CNT_W:0]   gap_sum;
      status_type       status_v;

      do_end    = 1'b0;
      pull_ok   = 1'b0;
      status_v  = STAT_NONE;
      stalled   = ticks_ff > tmo_ff;
      tick_next = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
      seq_diff  = req_chan.seq - exp_seq_ff;
      gap_sum   = {1'b0, gaps_ff} + (CNT_W+1)'(seq_diff);

      wr_ptr_in     = wr_ptr_ff;
      rd_word_in    = rd_word_ff;
      fill_in       = fill_ff;
      chunk_in      = chunk_ff;
      mode_in       = mode_ff;
      end_seen_in   = end_seen_ff;
      seq_known_in  = seq_known_ff;
      exp_seq_in    = exp_seq_ff;
      ticks_in      = ticks_ff;
      bytes_in      = bytes_ff;
      packets_in    = packets_ff;
      drops_in      = drops_ff;
      gaps_in       = gaps_ff;
      unders_in     = unders_ff;
      idle_drops_in = idle_drops_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;

      if (req_fire) begin
         unique case (cmd_type'(req_chan.command))
            CMD_START: begin
               wr_ptr_in     = '0;
               rd_word_in    = '0;
               fill_in       = '0;
               chunk_in      = '0;
               end_seen_in   = 1'b0;
               seq_known_in  = 1'b0;
               bytes_in      = '0;
               packets_in    = '0;
               drops_in      = '0;
               gaps_in       = '0;
               idle_drops_in = '0;
               ticks_in      = '0;
               mode_in       = MODE_BUFFERING;
            end
            CMD_AUDIO: begin
               if (mode_ff == MODE_IDLE) begin
                  idle_drops_in = (idle_drops_ff == '1) ? idle_drops_ff : idle_drops_ff + 1'b1;
               end else begin
                  ticks_in = '0;
                  if (req_chan.packet_start) begin
                     if (seq_known_ff && req_chan.seq != exp_seq_ff) begin
                        gaps_in = (gap_sum > (CNT_W+1)'({CNT_W{1'b1}})) ? '1
                                                                         : gap_sum[CNT_W-1:0];
                     end
                     exp_seq_in   = req_chan.seq + 1'b1;
                     seq_known_in = 1'b1;
                     packets_in   = (packets_ff == '1) ? packets_ff : packets_ff + 1'b1;
                  end
                  if (fill_ff < LVL_W'(RING_BYTES)) begin
                     mem_we    = 1'b1;
                     wr_ptr_in = (wr_ptr_ff == PTR_W'(RING_BYTES - 1)) ? '0
                                                                       : wr_ptr_ff + 1'b1;
                     fill_in   = fill_ff + 1'b1;
                     bytes_in  = (bytes_ff == '1) ? bytes_ff : bytes_ff + 1'b1;
                  end else begin
                     drops_in = (drops_ff == '1) ? drops_ff : drops_ff + 1'b1;
                  end
               end
            end
            CMD_END: begin
               end_seen_in = 1'b1;
            end
            CMD_CANCEL: begin
               if (mode_ff != MODE_IDLE) begin
                  do_end   = 1'b1;
                  status_v = STAT_ABORTED;
               end
            end
            CMD_TICK: begin
               ticks_in = tick_next;
               if (mode_ff == MODE_BUFFERING) begin
                  if ((tick_next > tmo_ff) && fill_ff == '0) begin
                     do_end   = 1'b1;
                     status_v = STAT_STALL_RST;
                  end else if (fill_ff >= LVL_W'(thr_ff) ||
                               ((end_seen_ff || (tick_next > tmo_ff)) && fill_ff != '0)) begin
                     mode_in  = MODE_PLAYING;
                     status_v = STAT_STARTED;
                  end
               end
            end
            CMD_PULL: begin
               if (mode_ff == MODE_PLAYING || mode_ff == MODE_DRAINING) begin
                  pull_ok = 1'b1;
                  if (mode_ff == MODE_PLAYING && end_seen_ff) mode_in = MODE_DRAINING;
                  if (chunk_ff == '0) begin
                     if (fill_ff >= LVL_W'(2 * CHUNK_SAMPLES)) begin
                        chunk_in = CHUNK_W'(CHUNK_SAMPLES);
                     end else if (mode_in == MODE_DRAINING) begin
                        // Take the whole samples left; an odd last byte stays unplayed.
                        chunk_in = CHUNK_W'(fill_ff >> 1);
                        if (fill_ff < LVL_W'(2)) begin
                           do_end   = 1'b1;
                           status_v = STAT_FINISHED;
                           pull_ok  = 1'b0;
                        end
                     end else begin
                        pull_ok = 1'b0;
                        if (!end_seen_ff && stalled) begin
                           do_end   = 1'b1;
                           status_v = STAT_FINISHED;
                        end else begin
                           unders_in = (unders_ff == '1) ? unders_ff : unders_ff + 1'b1;
                           status_v  = STAT_UNDERRUN;
                        end
                     end
                  end
                  if (pull_ok) begin
                     mem_re     = 1'b1;
                     rd_word_in = (rd_word_ff == WORD_W'(WORDS - 1)) ? '0 : rd_word_ff + 1'b1;
                     fill_in    = (fill_ff >= LVL_W'(2)) ? fill_ff - LVL_W'(2) : '0;
                     chunk_in   = chunk_in - 1'b1;
                     if (chunk_in == '0 && mode_in == MODE_DRAINING && fill_in == '0) begin
                        do_end   = 1'b1;
                        status_v = STAT_FINISHED;
                     end
                  end
               end
            end
            default: begin
               // Unused command codes change nothing.
            end
         endcase
      end

      // Stream end: back to idle with an empty ring; rx counters stay.
      if (do_end) begin
         mode_in     = MODE_IDLE;
         end_seen_in = 1'b0;
         wr_ptr_in   = '0;
         rd_word_in  = '0;
         fill_in     = '0;
         chunk_in    = '0;
         unders_in   = '0;
      end

      s1_in.sample_read          = pull_ok;
      s1_in.vol                  = vol_ff;
      s1_in.info.status          = status_v;
      s1_in.info.mode            = mode_in;
      s1_in.info.ring_level      = LEVEL_W'(fill_in);
      s1_in.info.rx_bytes        = bytes_in;
      s1_in.info.rx_chunks       = packets_in;
      s1_in.info.rx_dropped      = drops_in;
      s1_in.info.seq_gaps        = gaps_in;
      s1_in.info.underruns       = unders_in;
      s1_in.info.idle_drop_bytes = idle_drops_in;
   end

   //------------------------------------------------------------------
   // Output formation: volume shift of the read sample, copied to both
   // channels, and the channel drive.
   //------------------------------------------------------------------
   always_comb begin
      logic signed [SAMPLE_W-1:0] shifted;

      // The shift is kept in a signed variable of its own so that it stays arithmetic.
      shifted             = $signed(ring_rd_ff) >>> s1_ff.vol;
      out_in.sample_valid = s1_ff.sample_read;
      out_in.sample       = s1_ff.sample_read ? shifted : '0;
      out_in.info         = s1_ff.info;

      req_chan.ready           = req_ready;
      rsp_chan.valid           = out_valid_ff;
      rsp_chan.sample_valid    = out_ff.sample_valid;
      rsp_chan.sample_left     = out_ff.sample;
      rsp_chan.sample_right    = out_ff.sample;
      rsp_chan.status          = out_ff.info.status;
      rsp_chan.stream_state    = out_ff.info.mode;
      rsp_chan.ring_level      = out_ff.info.ring_level;
      rsp_chan.rx_bytes        = out_ff.info.rx_bytes;
      rsp_chan.rx_chunks       = out_ff.info.rx_chunks;
      rsp_chan.rx_dropped      = out_ff.info.rx_dropped;
      rsp_chan.seq_gaps        = out_ff.info.seq_gaps;
      rsp_chan.underruns       = out_ff.info.underruns;
      rsp_chan.idle_drop_bytes = out_ff.info.idle_drop_bytes;
   end

   //------------------------------------------------------------------
   // Ring memory: one port, byte-lane writes, registered word read.
   //------------------------------------------------------------------
   assign mem_addr = mem_we ? wr_ptr_ff[PTR_W-1:1] : rd_word_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         if (wr_ptr_ff[0]) begin
            ring_mem[mem_addr][2*BYTE_W-1:BYTE_W] <= req_chan.data_byte;
         end else begin
            ring_mem[mem_addr][BYTE_W-1:0] <= req_chan.data_byte;
         end
      end
      if (mem_re) begin
         ring_rd_ff <= ring_mem[mem_addr];
      end
   end

   //------------------------------------------------------------------
   // State and pipeline registers.
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_word_ff    <= '0;
         fill_ff       <= '0;
         chunk_ff      <= '0;
         mode_ff       <= MODE_IDLE;
         end_seen_ff   <= 1'b0;
         seq_known_ff  <= 1'b0;
         exp_seq_ff    <= '0;
         ticks_ff      <= '0;
         bytes_ff      <= '0;
         packets_ff    <= '0;
         drops_ff      <= '0;
         gaps_ff       <= '0;
         unders_ff     <= '0;
         idle_drops_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_word_ff    <= rd_word_in;
         fill_ff       <= fill_in;
         chunk_ff      <= chunk_in;
         mode_ff       <= mode_in;
         end_seen_ff   <= end_seen_in;
         seq_known_ff  <= seq_known_in;
         exp_seq_ff    <= exp_seq_in;
         ticks_ff      <= ticks_in;
         bytes_ff      <= bytes_in;
         packets_ff    <= packets_in;
         drops_ff      <= drops_in;
         gaps_ff       <= gaps_in;
         unders_ff     <= unders_in;
         idle_drops_ff <= idle_drops_in;
         if (req_ready) s1_valid_ff <= req_fire;
         if (out_free) out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) s1_ff <= s1_in;
      if (out_free && s1_valid_ff) out_ff <= out_in;
   end

   //------------------------------------------------------------------
   // Assertions.
   //------------------------------------------------------------------
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> fill_ff == '0 && chunk_ff == '0)
      else $error("idle stream holds ring data or an open chunk");

   a_chunk_covered: assert property (@(posedge clock) disable iff (reset)
      chunk_ff != '0 |-> fill_ff >= LVL_W'({chunk_ff, 1'b0}))
      else $error("reserved chunk exceeds the bytes in the ring");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && out_valid_ff && !rsp_chan.ready)
      else $error("request side blocked while the pipeline has room");

endmodule
